/* rtl/psch_pkg.sv */
// ----------------------------------------------------------------------------
// psch_pkg
// Shared widths, types and defaults of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package psch_pkg;

  localparam int MAX_PROCESSES_DEF = 16;

  localparam int ARR_W = 16;
  localparam int BUR_W = 16;
  localparam int PRI_W = 8;
  localparam int NUM_W = 5;
  localparam int FIN_W = 21;
  localparam int TAT_W = 20;
  localparam int WAIT_W = 20;

  localparam int IN_DATA_W  = 40;   // 16 + 16 + 8
  localparam int OUT_DATA_W = 72;   // 5 + 21 + 20 + 20 = 66, padded to bytes
  localparam int OUT_PAD_W  = OUT_DATA_W - NUM_W - FIN_W - TAT_W - WAIT_W;

  // record memory word: {arrival, burst, priority}
  localparam int REC_W = ARR_W + BUR_W + PRI_W;
  // progress memory word: {remaining, finish}
  localparam int PRG_W = BUR_W + FIN_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_DRAIN  = 4'b1000
  } state_t;

  // selection result of one scan round
  typedef struct packed {
    logic             have_pick;
    logic             have_next;
    logic [PRI_W-1:0] pick_pri;
    logic [ARR_W-1:0] pick_arr;
    logic [BUR_W-1:0] pick_rem;
    logic [ARR_W-1:0] next_arr;
  } sel_t;

endpackage

/* rtl/psch_ram.sv */
// ----------------------------------------------------------------------------
// psch_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module psch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/psch_select.sv */
// ----------------------------------------------------------------------------
// psch_select
// Running selection over one scan: best ready process and next arrival.
// ----------------------------------------------------------------------------
module psch_select #(
  parameter int IDX_W  = 4,
  parameter int TICK_W = 21
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     eval,
  input  logic [TICK_W-1:0]        tick,
  input  logic [IDX_W-1:0]         cand_idx,
  input  logic [psch_pkg::ARR_W-1:0] cand_arr,
  input  logic [psch_pkg::PRI_W-1:0] cand_pri,
  input  logic [psch_pkg::BUR_W-1:0] cand_rem,
  output psch_pkg::sel_t           sel,
  output logic [IDX_W-1:0]         pick_idx
);

  logic arrived;
  logic better;
  logic sooner;

  assign arrived = {{(TICK_W-psch_pkg::ARR_W){1'b0}}, cand_arr} <= tick;
  // strict compares keep the lower index on a full tie
  assign better  = !sel.have_pick || (cand_pri < sel.pick_pri) ||
                   ((cand_pri == sel.pick_pri) && (cand_arr < sel.pick_arr));
  assign sooner  = !sel.have_next || (cand_arr < sel.next_arr);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sel.have_pick <= 1'b0;
      sel.have_next <= 1'b0;
    end else if (eval && (cand_rem != '0)) begin
      if (arrived) begin
        if (better) begin
          sel.have_pick <= 1'b1;
          sel.pick_pri  <= cand_pri;
          sel.pick_arr  <= cand_arr;
          sel.pick_rem  <= cand_rem;
          pick_idx      <= cand_idx;
        end
      end else if (sooner) begin
        sel.have_next <= 1'b1;
        sel.next_arr  <= cand_arr;
      end
    end
  end

endmodule

/* rtl/preemptive_priority_scheduler.sv */
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Loads process records, schedules them by preemptive priority and streams
// per-process finish, turnaround and waiting times in load order.
// ----------------------------------------------------------------------------
// Loading: one record word per cycle, no result.
// Pass: each round scans all n loaded entries from memory through the registered
//   read port, then writes back the pick; a pass has at most 2n rounds, one per
//   completion and one per distinct arrival time.
// Drain: result words through the shared memory read port, one read in flight at a time.
// Reset clears the control state; the record memories are not cleared.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_PROCESSES = psch_pkg::MAX_PROCESSES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave side
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] arrival_time, [31:16] burst_time, [39:32] priority_level
  input  logic [psch_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,   // last_process
  // master side
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [4:0] process_number, [25:5] finish_time, [45:26] turnaround,
  // [65:46] waiting, [71:66] zero
  output logic [psch_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast    // last_result
);

  localparam int IW     = $clog2(MAX_PROCESSES);
  localparam int CW     = $clog2(MAX_PROCESSES + 1);
  // arrival plus the sum of all bursts stays below 2^16 * (MAX + 1); never
  // narrower than the finish field
  localparam int TICK_W = (psch_pkg::ARR_W + CW > psch_pkg::FIN_W) ?
                          psch_pkg::ARR_W + CW : psch_pkg::FIN_W;

  localparam int ARR_W = psch_pkg::ARR_W;
  localparam int BUR_W = psch_pkg::BUR_W;
  localparam int PRI_W = psch_pkg::PRI_W;
  localparam int FIN_W = psch_pkg::FIN_W;
  localparam int TAT_W = psch_pkg::TAT_W;

  psch_pkg::state_t state;

  logic [CW-1:0]     count;     // loaded entries, n during a pass
  logic [CW-1:0]     done;      // completed processes in the pass
  logic [CW-1:0]     idx;       // scan read address
  logic [CW-1:0]     o_idx;     // drain read address
  logic [IW-1:0]     ev_idx;    // entry whose read data is on the bus
  logic              rd_vld;    // scan read data valid
  logic              out_pend;  // drain read in flight
  logic [TICK_W-1:0] tick;

  // input word fields
  logic [ARR_W-1:0] in_arr;
  logic [BUR_W-1:0] in_bur;
  logic [PRI_W-1:0] in_pri;
  logic [BUR_W-1:0] in_bur_sat;
  logic             s_fire;
  logic             room;

  assign in_arr     = s_tdata[ARR_W-1:0];
  assign in_bur     = s_tdata[ARR_W+BUR_W-1:ARR_W];
  assign in_pri     = s_tdata[ARR_W+BUR_W+PRI_W-1:ARR_W+BUR_W];
  // a zero burst is stored as one tick
  assign in_bur_sat = (in_bur == '0) ? BUR_W'(1) : in_bur;
  assign s_tready   = (state == psch_pkg::ST_IDLE);
  assign s_fire     = s_tvalid && s_tready;
  assign room       = (count < CW'(MAX_PROCESSES));

  // memories
  logic                       rec_we;
  logic [psch_pkg::REC_W-1:0] rec_wdata;
  logic [psch_pkg::REC_W-1:0] rec_rdata;
  logic                       prg_we;
  logic [IW-1:0]              prg_waddr;
  logic [psch_pkg::PRG_W-1:0] prg_wdata;
  logic [psch_pkg::PRG_W-1:0] prg_rdata;
  logic [IW-1:0]              raddr;

  logic [ARR_W-1:0] rd_arr;
  logic [BUR_W-1:0] rd_bur;
  logic [PRI_W-1:0] rd_pri;
  logic [BUR_W-1:0] rd_rem;
  logic [FIN_W-1:0] rd_fin;

  assign rd_arr = rec_rdata[psch_pkg::REC_W-1:BUR_W+PRI_W];
  assign rd_bur = rec_rdata[BUR_W+PRI_W-1:PRI_W];
  assign rd_pri = rec_rdata[PRI_W-1:0];
  assign rd_rem = prg_rdata[psch_pkg::PRG_W-1:FIN_W];
  assign rd_fin = prg_rdata[FIN_W-1:0];

  // selection unit
  psch_pkg::sel_t sel;
  logic [IW-1:0]  pick_idx;
  logic           sel_clear;

  // a new scan round starts after a last record or after each write-back
  assign sel_clear = (s_fire && s_tlast) || (state == psch_pkg::ST_UPDATE);

  psch_select #(
    .IDX_W  (IW),
    .TICK_W (TICK_W)
  ) u_select (
    .clk      (clk),
    .rst      (rst),
    .clear    (sel_clear),
    .eval     (rd_vld),
    .tick     (tick),
    .cand_idx (ev_idx),
    .cand_arr (rd_arr),
    .cand_pri (rd_pri),
    .cand_rem (rd_rem),
    .sel      (sel),
    .pick_idx (pick_idx)
  );

  // write-back arithmetic: run the pick until it ends or the next arrival
  logic [TICK_W-1:0] gap;
  logic              cut;
  logic [BUR_W-1:0]  span;
  logic [BUR_W-1:0]  new_rem;
  logic [TICK_W-1:0] tick_new;
  logic [CW-1:0]     done_next;

  assign gap      = {{(TICK_W-ARR_W){1'b0}}, sel.next_arr} - tick;
  assign cut      = sel.have_next &&
                    (gap < {{(TICK_W-BUR_W){1'b0}}, sel.pick_rem});
  assign span     = cut ? gap[BUR_W-1:0] : sel.pick_rem;
  assign new_rem  = sel.pick_rem - span;
  assign tick_new = tick + {{(TICK_W-BUR_W){1'b0}}, span};
  assign done_next = (new_rem == '0) ? done + CW'(1) : done;

  // memory port muxing
  assign rec_we    = s_fire && room;
  assign rec_wdata = {in_arr, in_bur_sat, in_pri};
  assign prg_we    = rec_we || ((state == psch_pkg::ST_UPDATE) && sel.have_pick);
  assign prg_waddr = (state == psch_pkg::ST_UPDATE) ? pick_idx : count[IW-1:0];
  assign prg_wdata = (state == psch_pkg::ST_UPDATE) ? {new_rem, tick_new[FIN_W-1:0]}
                                                    : {in_bur_sat, {FIN_W{1'b0}}};
  assign raddr     = (state == psch_pkg::ST_DRAIN) ? o_idx[IW-1:0] : idx[IW-1:0];

  psch_ram #(
    .WIDTH (psch_pkg::REC_W),
    .DEPTH (MAX_PROCESSES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (count[IW-1:0]),
    .wdata (rec_wdata),
    .raddr (raddr),
    .rdata (rec_rdata)
  );

  psch_ram #(
    .WIDTH (psch_pkg::PRG_W),
    .DEPTH (MAX_PROCESSES)
  ) u_prg_ram (
    .clk   (clk),
    .we    (prg_we),
    .waddr (prg_waddr),
    .wdata (prg_wdata),
    .raddr (raddr),
    .rdata (prg_rdata)
  );

  // result arithmetic, modulo the field widths
  logic [FIN_W-1:0] tat_full;
  logic [TAT_W-1:0] tat;
  logic [TAT_W-1:0] wt;
  logic             issue;
  logic             last_out;

  assign tat_full = rd_fin - {{(FIN_W-ARR_W){1'b0}}, rd_arr};
  assign tat      = tat_full[TAT_W-1:0];
  assign wt       = tat - {{(TAT_W-BUR_W){1'b0}}, rd_bur};
  // read the next entry only when the output register is free next cycle
  assign issue    = (state == psch_pkg::ST_DRAIN) && !out_pend &&
                    (!m_tvalid || m_tready);
  assign last_out = ((o_idx + CW'(1)) == count);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= psch_pkg::ST_IDLE;
      count    <= '0;
      done     <= '0;
      idx      <= '0;
      o_idx    <= '0;
      rd_vld   <= 1'b0;
      out_pend <= 1'b0;
      tick     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld   <= (state == psch_pkg::ST_SCAN) && (idx < count);
      ev_idx   <= idx[IW-1:0];
      out_pend <= issue;

      case (state)
        psch_pkg::ST_IDLE: begin
          if (s_fire) begin
            if (room) begin
              count <= count + CW'(1);
            end
            if (s_tlast) begin
              state <= psch_pkg::ST_SCAN;
              idx   <= '0;
              done  <= '0;
              tick  <= '0;
            end
          end
        end
        psch_pkg::ST_SCAN: begin
          // the last entry is evaluated in the cycle that idx reaches count
          if (idx == count) begin
            state <= psch_pkg::ST_UPDATE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        psch_pkg::ST_UPDATE: begin
          idx <= '0;
          if (sel.have_pick) begin
            tick <= tick_new;
            done <= done_next;
            if (done_next == count) begin
              state <= psch_pkg::ST_DRAIN;
              o_idx <= '0;
            end else begin
              state <= psch_pkg::ST_SCAN;
            end
          end else begin
            // nothing ready: jump to the next arrival
            tick  <= {{(TICK_W-ARR_W){1'b0}}, sel.next_arr};
            state <= psch_pkg::ST_SCAN;
          end
        end
        psch_pkg::ST_DRAIN: begin
          if (out_pend) begin
            o_idx <= o_idx + CW'(1);
            if (last_out) begin
              state <= psch_pkg::ST_IDLE;
              count <= '0;
            end
          end
        end
        default: begin
          state <= psch_pkg::ST_IDLE;
        end
      endcase

      // hold the result word until taken
      if (out_pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload
  logic [psch_pkg::NUM_W-1:0] num;

  assign num = psch_pkg::NUM_W'(o_idx + CW'(1));

  always_ff @(posedge clk) begin
    if (out_pend) begin
      m_tdata <= {{psch_pkg::OUT_PAD_W{1'b0}}, wt, tat, rd_fin, num};
      m_tlast <= last_out;
    end
  end

  // checks
  a_done_below_n: assert property (@(posedge clk) disable iff (rst)
    (state == psch_pkg::ST_SCAN) |-> (done < count))
    else $error("completion count reached n inside a scan");

  a_pick_has_work: assert property (@(posedge clk) disable iff (rst)
    ((state == psch_pkg::ST_UPDATE) && sel.have_pick) |-> (sel.pick_rem != '0))
    else $error("picked process has no remaining work");

  a_idle_has_arrival: assert property (@(posedge clk) disable iff (rst)
    ((state == psch_pkg::ST_UPDATE) && !sel.have_pick) |-> sel.have_next)
    else $error("idle round without a pending arrival");

  a_pend_loads_out: assert property (@(posedge clk) disable iff (rst)
    out_pend |=> m_tvalid)
    else $error("drain read did not reach the output register");

  a_issue_free_slot: assert property (@(posedge clk) disable iff (rst)
    out_pend |-> !m_tvalid)
    else $error("drain read landed on an occupied output register");

endmodule
